// ----- design/dcwfr_pkg.sv -----
// package for the duty-cycle wire frame receiver
// transfer item types and reset constants, no dependencies
package dcwfr_pkg;

    localparam int          PACKET_BITS_DEF   = 9;
    localparam int          SAMPLE_DELAY_W    = 16;
    localparam int          READING_W         = 16;
    localparam logic [15:0] SAMPLE_DELAY_RST  = 16'd400;

    typedef struct packed {
        logic start_request;
        logic line_level;
    } t_in_item;

    typedef struct packed {
        logic                 power_enable;
        logic                 done_res;
        logic                 parity_ok;
        logic [READING_W-1:0] reading;
    } t_out_item;

endpackage

// ----- design/duty_cycle_wire_frame_receiver.sv -----
// a result is registered into the output register, or into the skid entry while the output is stalled
// throughput: one tick per cycle while o_in_stall is low; each input transfer yields exactly one result
// a two-entry output buffer keeps input transfers going while one result waits
// reset (synchronous, active low): sequencer idle, buffer empty, sample delay 400
// depends on dcwfr_pkg and dcwfr_fsm
module duty_cycle_wire_frame_receiver
    import dcwfr_pkg::*;
#(
    parameter int PACKET_BITS = PACKET_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_item                  i_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [SAMPLE_DELAY_W-1:0] i_cfg_data
);

    logic [SAMPLE_DELAY_W-1:0] r_sample_delay;
    logic                      r_out_valid;
    t_out_item                 r_out;
    logic                      r_skid_valid;
    t_out_item                 r_skid;
    t_out_item                 w_result;
    logic                      w_in_fire;
    logic                      w_out_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_item      = r_out;
    assign w_in_fire   = i_in_valid && !r_skid_valid;
    assign w_out_fire  = r_out_valid && !i_out_stall;

    dcwfr_fsm #(
        .PACKET_BITS (PACKET_BITS)
    ) u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_in_fire),
        .i_item         (i_item),
        .i_sample_delay (r_sample_delay),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_delay <= SAMPLE_DELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sample_delay <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_fire) begin
            if (!r_out_valid || w_out_fire) begin
                r_out       <= w_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_result;
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_done_powers_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_item.done_res) |-> !o_item.power_enable)
        else $error("supply still on at frame end");

    a_bad_parity_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_item.parity_ok) |-> (o_item.reading == '0))
        else $error("reading not cleared without good parity");

    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_item.parity_ok) |-> o_item.done_res)
        else $error("parity flag without frame end");
`endif

endmodule

// ----- design/dcwfr_fsm.sv -----
// frame sequencer: one tick per step, settle wait, start bits, bit timing
// depends on dcwfr_pkg
module dcwfr_fsm
    import dcwfr_pkg::*;
#(
    parameter int PACKET_BITS = PACKET_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  t_in_item                  i_item,
    input  logic [SAMPLE_DELAY_W-1:0] i_sample_delay,
    output t_out_item                 o_result
);

    localparam int BW = (PACKET_BITS > 1) ? $clog2(PACKET_BITS) : 1;
    localparam int CW = SAMPLE_DELAY_W + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_START_LOW,
        PH_STROBE_END,
        PH_WAIT_FALL,
        PH_BIT_DELAY,
        PH_WAIT_HIGH
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [CW-1:0]          r_delay_count, n_delay_count;
    logic [BW-1:0]          r_bit_index, n_bit_index;
    logic                   r_packet_index, n_packet_index;
    logic [PACKET_BITS-1:0] r_first, n_first;
    logic [PACKET_BITS-1:0] r_second, n_second;
    logic                   n_done;
    logic                   n_advance;
    logic [BW-1:0]          w_pos;
    logic [31:0]            w_word;

    assign w_pos = BW'(PACKET_BITS - 1) - r_bit_index;

    always_comb begin
        n_phase        = r_phase;
        n_delay_count  = r_delay_count;
        n_bit_index    = r_bit_index;
        n_packet_index = r_packet_index;
        n_first        = r_first;
        n_second       = r_second;
        n_done         = 1'b0;
        n_advance      = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (i_item.start_request) begin
                    n_delay_count  = {i_sample_delay, 1'b0};
                    n_bit_index    = '0;
                    n_packet_index = 1'b0;
                    n_first        = '0;
                    n_second       = '0;
                    n_phase        = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (r_delay_count <= CW'(1)) begin
                    n_delay_count = '0;
                    n_phase       = PH_START_LOW;
                end else begin
                    n_delay_count = r_delay_count - CW'(1);
                end
            end
            PH_START_LOW: begin
                if (!i_item.line_level) n_phase = PH_STROBE_END;
            end
            PH_STROBE_END: begin
                if (i_item.line_level) n_phase = PH_WAIT_FALL;
            end
            PH_WAIT_FALL: begin
                if (!i_item.line_level) begin
                    n_delay_count = CW'(i_sample_delay);
                    n_phase       = PH_BIT_DELAY;
                end
            end
            PH_BIT_DELAY: begin
                if (r_delay_count != '0) begin
                    n_delay_count = r_delay_count - CW'(1);
                end else begin
                    if (i_item.line_level) begin
                        if (r_packet_index) n_second[w_pos] = 1'b1;
                        else                n_first[w_pos]  = 1'b1;
                        n_advance = 1'b1;
                    end else begin
                        n_phase = PH_WAIT_HIGH;
                    end
                end
            end
            PH_WAIT_HIGH: begin
                if (i_item.line_level) n_advance = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // step to the next bit, next packet or end of frame
        if (n_advance) begin
            if (r_bit_index == BW'(PACKET_BITS - 1)) begin
                n_bit_index = '0;
                if (!r_packet_index) begin
                    n_packet_index = 1'b1;
                    n_phase        = PH_START_LOW;
                end else begin
                    n_packet_index = 1'b0;
                    n_phase        = PH_IDLE;
                    n_done         = 1'b1;
                end
            end else begin
                n_bit_index = r_bit_index + BW'(1);
                n_phase     = PH_WAIT_FALL;
            end
        end
    end

    // data bits of both packets, parity bits dropped
    assign w_word = (32'(n_first[PACKET_BITS-1:1]) << (PACKET_BITS - 1))
                  | 32'(n_second[PACKET_BITS-1:1]);

    always_comb begin
        o_result              = '0;
        o_result.power_enable = (n_phase != PH_IDLE);
        o_result.done_res     = n_done;
        if (n_done && !(^n_first) && !(^n_second)) begin
            o_result.parity_ok = 1'b1;
            o_result.reading   = w_word[READING_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_delay_count  <= '0;
            r_bit_index    <= '0;
            r_packet_index <= 1'b0;
            r_first        <= '0;
            r_second       <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_delay_count  <= n_delay_count;
            r_bit_index    <= n_bit_index;
            r_packet_index <= n_packet_index;
            r_first        <= n_first;
            r_second       <= n_second;
        end
    end

endmodule

// ----- test/tb_duty_cycle_wire_frame_receiver.sv -----
// self-checking testbench for duty_cycle_wire_frame_receiver
// drives wire ticks per transfer and checks each result against an in-file frame decoder
// depends on dcwfr_pkg and the receiver rtl
module tb_duty_cycle_wire_frame_receiver
    import dcwfr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PKT_BITS = PACKET_BITS_DEF;
    localparam int unsigned LIMIT    = 500000;
    localparam int          QUOTA    = 50;

    typedef enum logic [2:0] {
        S_IDLE, S_SETTLE, S_START_LOW, S_STROBE_END, S_WAIT_FALL, S_BIT_DELAY, S_WAIT_HIGH
    } t_seq_phase;

    typedef enum logic {ROW_QUIET, ROW_FRAME} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        logic [15:0]         delay;
        logic [PKT_BITS-1:0] pkt_a;
        logic [PKT_BITS-1:0] pkt_b;
        t_out_item           exp;
    } t_dir_row;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_in_item                  i_item      = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_item                 o_item;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [SAMPLE_DELAY_W-1:0] i_cfg_data  = '0;

    // decoder state, mirrors the sequencer
    t_seq_phase          m_phase = S_IDLE;
    logic [16:0]         m_count = '0;
    int                  m_bit   = 0;
    logic                m_pkt   = 1'b0;
    logic [PKT_BITS-1:0] m_pkt_a = '0;
    logic [PKT_BITS-1:0] m_pkt_b = '0;
    logic [15:0]         m_delay = SAMPLE_DELAY_RST;

    t_out_item   expected_results[$];
    t_out_item   last_result;
    int          tick_count = 0;
    int          errors     = 0;
    int          send_pct   = 0;
    int          stall_pct  = 0;
    int unsigned cycles     = 0;

    int send_pcts  [4] = '{0, 86, 0, 25};
    int stall_pcts [4] = '{0, 0, 86, 25};

    t_dir_row directed_rows [9] = '{
        '{ROW_QUIET, 16'd400, 9'h000, 9'h000, '{1'b0, 1'b0, 1'b0, 16'h0000}},
        '{ROW_FRAME, 16'd4,   9'h1FE, 9'h000, '{1'b0, 1'b1, 1'b1, 16'hFF00}},
        '{ROW_FRAME, 16'd0,   9'h1FE, 9'h1FE, '{1'b0, 1'b1, 1'b1, 16'hFFFF}},
        '{ROW_FRAME, 16'd0,   9'h000, 9'h000, '{1'b0, 1'b1, 1'b1, 16'h0000}},
        '{ROW_FRAME, 16'd1,   9'h1FF, 9'h000, '{1'b0, 1'b1, 1'b0, 16'h0000}},
        '{ROW_FRAME, 16'd1,   9'h000, 9'h001, '{1'b0, 1'b1, 1'b0, 16'h0000}},
        '{ROW_FRAME, 16'd2,   9'h154, 9'h0AA, '{1'b0, 1'b1, 1'b1, 16'hAA55}},
        '{ROW_FRAME, 16'd3,   9'h101, 9'h003, '{1'b0, 1'b1, 1'b1, 16'h8001}},
        '{ROW_QUIET, 16'd3,   9'h000, 9'h000, '{1'b0, 1'b0, 1'b0, 16'h0000}}
    };

    duty_cycle_wire_frame_receiver #(
        .PACKET_BITS (PKT_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (i_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < 40)
            $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic logic advance_bit();
        m_bit++;
        if (m_bit < PKT_BITS) begin
            m_phase = S_WAIT_FALL;
            return 1'b0;
        end
        m_bit = 0;
        if (!m_pkt) begin
            m_pkt   = 1'b1;
            m_phase = S_START_LOW;
            return 1'b0;
        end
        m_pkt   = 1'b0;
        m_phase = S_IDLE;
        return 1'b1;
    endfunction

    function automatic t_out_item decode_tick(logic start, logic line);
        t_out_item r;
        logic      fin;
        r   = '0;
        fin = 1'b0;
        case (m_phase)
            S_IDLE: if (start) begin
                m_count = {m_delay, 1'b0};
                m_bit   = 0;
                m_pkt   = 1'b0;
                m_pkt_a = '0;
                m_pkt_b = '0;
                m_phase = S_SETTLE;
            end
            S_SETTLE: if (m_count <= 17'd1) begin
                m_count = '0;
                m_phase = S_START_LOW;
            end else begin
                m_count--;
            end
            S_START_LOW:  if (!line) m_phase = S_STROBE_END;
            S_STROBE_END: if (line) m_phase = S_WAIT_FALL;
            S_WAIT_FALL: if (!line) begin
                m_count = 17'(m_delay);
                m_phase = S_BIT_DELAY;
            end
            S_BIT_DELAY: if (m_count != 0) begin
                m_count--;
            end else begin
                // msb first within each packet
                if (m_pkt)
                    m_pkt_b[PKT_BITS-1-m_bit] = line;
                else
                    m_pkt_a[PKT_BITS-1-m_bit] = line;
                if (line)
                    fin = advance_bit();
                else
                    m_phase = S_WAIT_HIGH;
            end
            S_WAIT_HIGH: if (line) fin = advance_bit();
            default: m_phase = S_IDLE;
        endcase
        if (fin && !(^m_pkt_a) && !(^m_pkt_b)) begin
            r.parity_ok = 1'b1;
            r.reading   = 16'((32'(m_pkt_a >> 1) << (PKT_BITS - 1)) | 32'(m_pkt_b >> 1));
        end
        r.power_enable = (m_phase != S_IDLE);
        r.done_res     = fin;
        return r;
    endfunction

    task automatic send_tick(input logic start, input logic line);
        t_in_item item;
        item.start_request = start;
        item.line_level    = line;
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_item     <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        last_result = decode_tick(start, line);
        expected_results.push_back(last_result);
        tick_count++;
    endtask

    // start requests while busy must be ignored
    function automatic logic stray_start();
        return (m_phase != S_IDLE) && ($urandom_range(7) == 0);
    endfunction

    task automatic write_sample_delay(input logic [15:0] value);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        m_delay = value;
    endtask

    task automatic send_frame(input logic [PKT_BITS-1:0] pkt_a, input logic [PKT_BITS-1:0] pkt_b,
                              output t_out_item frame_res);
        int                  lo_len;
        int                  hi_len;
        logic [PKT_BITS-1:0] pkt;
        frame_res = '0;
        send_tick(1'b1, 1'($urandom_range(1)));
        while (m_phase == S_SETTLE) send_tick(stray_start(), 1'($urandom_range(1)));
        repeat ($urandom_range(2)) send_tick(stray_start(), 1'b1);
        for (int p = 0; p < 2; p++) begin
            pkt = p ? pkt_b : pkt_a;
            // start bit low phase, then end of strobe
            repeat ($urandom_range(1, 3)) send_tick(stray_start(), 1'b0);
            repeat ($urandom_range(1, 3)) send_tick(stray_start(), 1'b1);
            for (int b = PKT_BITS - 1; b >= 0; b--) begin
                // a one rises by the sampling point and holds through it,
                // a zero stays low past it
                lo_len = pkt[b] ? $urandom_range(1, m_delay + 1)
                                : $urandom_range(m_delay + 2, m_delay + 4);
                hi_len = pkt[b] ? int'(m_delay) + 2 - lo_len + int'($urandom_range(2))
                                : int'($urandom_range(1, 3));
                repeat (lo_len) send_tick(stray_start(), 1'b0);
                repeat (hi_len) begin
                    send_tick(stray_start(), 1'b1);
                    if (last_result.done_res) frame_res = last_result;
                end
            end
        end
    endtask

    // steer whatever is in flight back to idle
    task automatic close_frame();
        while (m_phase != S_IDLE) begin
            case (m_phase)
                S_START_LOW, S_WAIT_FALL: send_tick(stray_start(), 1'b0);
                S_BIT_DELAY:              send_tick(stray_start(), 1'($urandom_range(1)));
                default:                  send_tick(stray_start(), 1'b1);
            endcase
        end
    endtask

    function automatic logic [PKT_BITS-1:0] random_packet();
        logic [PKT_BITS-2:0] data;
        data = (PKT_BITS - 1)'($urandom);
        return {data, ^data ^ ($urandom_range(4) == 0)};
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_item), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_item.power_enable !== want.power_enable)
                    report_mismatch("power_enable", 32'(o_item.power_enable),
                                    32'(want.power_enable));
                if (o_item.done_res !== want.done_res)
                    report_mismatch("done_res", 32'(o_item.done_res), 32'(want.done_res));
                if (o_item.parity_ok !== want.parity_ok)
                    report_mismatch("parity_ok", 32'(o_item.parity_ok), 32'(want.parity_ok));
                if (o_item.reading !== want.reading)
                    report_mismatch("reading", 32'(o_item.reading), 32'(want.reading));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb_duty_cycle_wire_frame_receiver NOT OK");
            $finish;
        end
    end

    initial begin
        t_out_item res;
        int        phase_start;
        int        pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_QUIET) begin
                repeat (3) begin
                    send_tick(1'b0, 1'($urandom_range(1)));
                    if (last_result !== directed_rows[i].exp)
                        report_mismatch($sformatf("row %0d", i), 32'(last_result),
                                        32'(directed_rows[i].exp));
                end
            end else begin
                if (directed_rows[i].delay != m_delay)
                    write_sample_delay(directed_rows[i].delay);
                send_frame(directed_rows[i].pkt_a, directed_rows[i].pkt_b, res);
                if (res !== directed_rows[i].exp)
                    report_mismatch($sformatf("row %0d", i), 32'(res),
                                    32'(directed_rows[i].exp));
            end
        end

        for (int m = 0; m < 4; m++) begin
            send_pct  = send_pcts[m];
            stall_pct = stall_pcts[m];
            for (int s = 0; s < 2; s++) begin
                write_sample_delay(($urandom_range(5) == 0) ? 16'd8 : 16'($urandom_range(4)));
                phase_start = tick_count;
                while (tick_count - phase_start < QUOTA) begin
                    pick = $urandom_range(99);
                    if (pick < 70) begin
                        send_frame(random_packet(), random_packet(), res);
                    end else if (pick < 85) begin
                        // broken sequences: random wire and start activity
                        repeat ($urandom_range(10, 60))
                            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                        close_frame();
                    end else begin
                        repeat ($urandom_range(1, 6)) send_tick(1'b0, 1'($urandom_range(1)));
                    end
                end
            end
        end

        send_pct  = 0;
        stall_pct = 0;
        write_sample_delay(16'hFFFF);
        repeat (8) send_tick(1'b0, 1'($urandom_range(1)));
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (errors == 0)
            $display("tb_duty_cycle_wire_frame_receiver OK");
        else
            $display("tb_duty_cycle_wire_frame_receiver NOT OK");
        $finish;
    end

endmodule

// ----- duty_cycle_wire_frame_receiver.f -----
design/dcwfr_pkg.sv
design/dcwfr_fsm.sv
design/duty_cycle_wire_frame_receiver.sv
test/tb_duty_cycle_wire_frame_receiver.sv
